[rtl/tbm_pkg.sv]
package tbm_pkg;

  localparam int MAX_BLOCKS    = 256;
  localparam int HOP_BITS      = 8;
  localparam int BLOCK_BITS    = $clog2(MAX_BLOCKS);
  localparam int PTR_BITS      = $clog2(MAX_BLOCKS) + 1;
  localparam int NODE_BITS     = BLOCK_BITS + 4;
  localparam int HOP_ADDR_BITS = NODE_BITS + 4;
  localparam int NODE_DEPTH    = 1 << NODE_BITS;
  localparam int HOP_DEPTH     = 1 << HOP_ADDR_BITS;
  localparam int ADDR_BITS     = 32;
  localparam int LEN_BITS      = 6;
  localparam int MAX_LEN       = 32;
  localparam int STRIDE        = 4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_HOP_READ,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [15:0]           child_map;
    logic [14:0]           prefix_map;
    logic [BLOCK_BITS-1:0] child_base;
  } node_t;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic descend;
    logic search;
    logic ins_final;
    logic ins_full;
    logic hop_read;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic insert;
    logic more;
    logic child_set;
    logic child_none;
    logic pool_out;
  } status_t;

  typedef struct packed {
    logic       found;
    logic [3:0] pos;
  } match_t;

  // in-node bit position of a k-bit prefix taken from the top of v
  function automatic logic [3:0] pos_of(input logic [2:0] v, input logic [1:0] k);
    logic [3:0] base;
    logic [2:0] b;
    base = 4'((4'd1 << k) - 4'd1);
    b    = v >> (2'd3 - k);
    return base + {1'b0, b};
  endfunction

  // longest in-node match, lengths r down to 0
  function automatic match_t in_node_search(input logic [14:0] pmap, input logic [2:0] v,
                                            input logic [1:0] r);
    match_t     m;
    logic [3:0] p;
    m = '0;
    for (int k = 3; k >= 0; k--) begin
      p = pos_of(v, 2'(k));
      if (!m.found && (k <= int'(r)) && pmap[p]) begin
        m.found = 1'b1;
        m.pos   = p;
      end
    end
    return m;
  endfunction

endpackage

[rtl/tbm_ctrl.sv]
module tbm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tbm_pkg::status_t st,
  output tbm_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);

  tbm_pkg::state_t state;
  tbm_pkg::state_t state_next;
  logic            no_block;

  assign no_block = st.more && !st.child_set && st.child_none && st.pool_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tbm_pkg::ST_CLEAR: begin
        if (st.clear_done) state_next = tbm_pkg::ST_IDLE;
      end
      tbm_pkg::ST_IDLE: begin
        if (start) state_next = tbm_pkg::ST_WALK;
      end
      tbm_pkg::ST_WALK: begin
        if (st.insert) begin
          if (no_block || !st.more) state_next = tbm_pkg::ST_RESULT;
        end else if (!(st.more && st.child_set)) begin
          state_next = tbm_pkg::ST_HOP_READ;
        end
      end
      tbm_pkg::ST_HOP_READ: state_next = tbm_pkg::ST_RESULT;
      tbm_pkg::ST_RESULT:   state_next = tbm_pkg::ST_IDLE;
      default:              state_next = tbm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      tbm_pkg::ST_CLEAR: cmd.clear_wr = 1'b1;
      tbm_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      tbm_pkg::ST_WALK: begin
        if (st.insert) begin
          if (!st.more) begin
            cmd.ins_final = 1'b1;
          end else if (no_block) begin
            cmd.ins_full = 1'b1;
          end else begin
            cmd.descend = 1'b1;
          end
        end else begin
          cmd.search  = 1'b1;
          cmd.descend = st.more && st.child_set;
        end
      end
      tbm_pkg::ST_HOP_READ: cmd.hop_read = 1'b1;
      tbm_pkg::ST_RESULT:   done = 1'b1;
      default:              busy = 1'b1;
    endcase
  end

endmodule

[rtl/tbm_datapath.sv]
module tbm_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  tbm_pkg::cmd_t                     cmd,
  output tbm_pkg::status_t                  st,
  input  logic                              op,
  input  logic [tbm_pkg::ADDR_BITS-1:0]     address,
  input  logic [tbm_pkg::LEN_BITS-1:0]      prefix_length,
  input  logic [7:0]                        next_hop,
  output logic                              hit,
  output logic [7:0]                        result_hop,
  output logic                              table_full
);

  tbm_pkg::node_t                      node_mem [tbm_pkg::NODE_DEPTH];
  logic [tbm_pkg::HOP_BITS-1:0]        hop_mem  [tbm_pkg::HOP_DEPTH];

  tbm_pkg::node_t                      rdata;
  logic [tbm_pkg::HOP_BITS-1:0]        hop_rdata;
  logic [tbm_pkg::NODE_BITS-1:0]       clr_cnt;
  logic [tbm_pkg::PTR_BITS-1:0]        ptr;
  logic                                ins;
  logic [tbm_pkg::ADDR_BITS-1:0]       a;
  logic [tbm_pkg::LEN_BITS-1:0]        rem;
  logic [tbm_pkg::HOP_BITS-1:0]        hop;
  logic [tbm_pkg::NODE_BITS-1:0]       node;
  logic [tbm_pkg::HOP_ADDR_BITS-1:0]   best;
  logic                                found;
  logic                                full;

  logic [3:0]                          chunk;
  logic [2:0]                          top3;
  logic [tbm_pkg::NODE_BITS-1:0]       next_node;
  logic [tbm_pkg::NODE_BITS-1:0]       rd_addr;
  logic [tbm_pkg::NODE_BITS-1:0]       wr_addr;
  tbm_pkg::node_t                      wdata;
  logic                                node_we;
  logic                                alloc;
  logic [3:0]                          ins_pos;
  tbm_pkg::match_t                     m;

  assign chunk = a[tbm_pkg::ADDR_BITS-1 -: tbm_pkg::STRIDE];
  assign top3  = a[tbm_pkg::ADDR_BITS-1 -: 3];

  assign st.clear_done = (clr_cnt == {tbm_pkg::NODE_BITS{1'b1}});
  assign st.insert     = ins;
  assign st.more       = (rem > tbm_pkg::LEN_BITS'(3));
  assign st.child_set  = rdata.child_map[chunk];
  assign st.child_none = (rdata.child_map == '0);
  assign st.pool_out   = (ptr >= tbm_pkg::PTR_BITS'(tbm_pkg::MAX_BLOCKS));

  assign alloc   = ins && !st.child_set && st.child_none;
  assign ins_pos = tbm_pkg::pos_of(top3, rem[1:0]);
  assign m       = tbm_pkg::in_node_search(rdata.prefix_map, top3,
                                           st.more ? 2'd3 : rem[1:0]);

  always_comb begin
    if (st.child_set) begin
      next_node = {rdata.child_base, chunk};
    end else begin
      next_node = {ptr[tbm_pkg::BLOCK_BITS-1:0], chunk};
    end
    if (!st.child_set && !st.child_none) next_node = {rdata.child_base, chunk};
  end

  assign rd_addr = cmd.load ? '0 : next_node;
  assign wr_addr = cmd.clear_wr ? clr_cnt : node;
  assign node_we = cmd.clear_wr || cmd.ins_final || (cmd.descend && ins && !st.child_set);

  always_comb begin
    wdata = rdata;
    if (cmd.clear_wr) begin
      wdata = '0;
    end else if (cmd.ins_final) begin
      wdata.prefix_map = rdata.prefix_map | (15'd1 << ins_pos);
    end else begin
      wdata.child_map = rdata.child_map | (16'd1 << chunk);
      if (alloc) wdata.child_base = ptr[tbm_pkg::BLOCK_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[wr_addr] <= wdata;
    rdata <= node_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_final) hop_mem[{node, ins_pos}] <= hop;
    if (cmd.hop_read) hop_rdata <= hop_mem[best];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      ptr     <= tbm_pkg::PTR_BITS'(1);
      found   <= 1'b0;
      full    <= 1'b0;
    end else begin
      if (cmd.clear_wr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.load) begin
        found <= 1'b0;
        full  <= 1'b0;
      end
      if (cmd.descend && alloc) ptr <= ptr + 1'b1;
      if (cmd.search && m.found) found <= 1'b1;
      if (cmd.ins_full) full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ins  <= op;
      a    <= address;
      rem  <= (prefix_length > tbm_pkg::LEN_BITS'(tbm_pkg::MAX_LEN)) ?
              tbm_pkg::LEN_BITS'(tbm_pkg::MAX_LEN) : prefix_length;
      hop  <= tbm_pkg::HOP_BITS'(next_hop);
      node <= '0;
    end else if (cmd.descend) begin
      a    <= a << tbm_pkg::STRIDE;
      rem  <= rem - tbm_pkg::LEN_BITS'(tbm_pkg::STRIDE);
      node <= next_node;
    end
    if (cmd.search && m.found) best <= {node, m.pos};
  end

  assign hit        = found;
  assign result_hop = found ? 8'(hop_rdata) : 8'd0;
  assign table_full = full;

endmodule

[rtl/tree_bitmap_ipv4_lpm_unit.sv]
// Lookup: the unit visits n nodes (n = 1..9) after the start transfer, then pulses done;
// one node memory read per node, then one hop memory read. Next start the cycle after done.
// Insert: done pulses after the walk over the nodes; node update is read-modify-write.
// One item at a time: start is taken only when idle, and busy stays high through done.
// Reset (rst, synchronous): a clearing pass over all 4096 node memory entries, busy held high.
// Results are shown for one cycle with done; the receiver cannot stall.
module tree_bitmap_ipv4_lpm_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [tbm_pkg::ADDR_BITS-1:0] address,
  input  logic [tbm_pkg::LEN_BITS-1:0]  prefix_length,
  input  logic [7:0]                    next_hop,
  output logic                          done,
  output logic                          hit,
  output logic [7:0]                    result_hop,
  output logic                          table_full
);

  tbm_pkg::cmd_t    cmd;
  tbm_pkg::status_t st;

  tbm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  tbm_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .op            (op),
    .address       (address),
    .prefix_length (prefix_length),
    .next_hop      (next_hop),
    .hit           (hit),
    .result_hop    (result_hop),
    .table_full    (table_full)
  );

endmodule

[tb/tree_bitmap_ipv4_lpm_unit_test.sv]
module tree_bitmap_ipv4_lpm_unit_test;

  localparam logic OP_LOOKUP     = 1'b0;
  localparam logic OP_INSERT     = 1'b1;
  localparam int   NODE_COUNT    = tbm_pkg::MAX_BLOCKS * 16;
  localparam int   HOPS_PER_NODE = 15;
  localparam int   IDLE_LIMIT    = 20000;
  localparam int   RANDOM_ITEMS  = 400;
  localparam int   TAIL_CYCLES   = 16;
  localparam int   CASE_COUNT    = 25;

  typedef struct packed {
    logic       hit;
    logic [7:0] hop;
    logic       full;
  } lpm_result_t;

  typedef struct packed {
    logic                          op;
    logic [tbm_pkg::ADDR_BITS-1:0] addr;
    logic [tbm_pkg::LEN_BITS-1:0]  len;
    logic [7:0]                    hop;
    logic                          typed;
    lpm_result_t                   want;
  } route_case_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic                          op;
  logic [tbm_pkg::ADDR_BITS-1:0] address;
  logic [tbm_pkg::LEN_BITS-1:0]  prefix_length;
  logic [7:0]                    next_hop;
  logic                          done;
  logic                          hit;
  logic [7:0]                    result_hop;
  logic                          table_full;

  tree_bitmap_ipv4_lpm_unit dut (.*);

  // shadow copy of the trie
  logic [15:0]                    child_bits  [NODE_COUNT];
  logic [14:0]                    prefix_bits [NODE_COUNT];
  logic [tbm_pkg::BLOCK_BITS-1:0] child_base  [NODE_COUNT];
  logic [7:0]                     hop_mem     [NODE_COUNT * HOPS_PER_NODE];
  int unsigned                    free_block;

  lpm_result_t                   pending_results [$];
  logic [tbm_pkg::ADDR_BITS-1:0] route_addrs [$];
  route_case_t                   directed_cases [CASE_COUNT];
  lpm_result_t                   oldest;
  int                            error_count;
  int                            idle_cycles;
  int                            burst_left;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int match_in_node(input int unsigned node, input int unsigned bits,
                                       input int unsigned r);
    int unsigned pos;
    int unsigned v;
    v = bits;
    for (int k = int'(r); k >= 0; k--) begin
      pos = ((1 << k) - 1) + v;
      if (pos < HOPS_PER_NODE && prefix_bits[node][pos]) return int'(pos);
      v = v >> 1;
    end
    return -1;
  endfunction

  function automatic lpm_result_t route_step(input logic op_i, input logic [31:0] addr_i,
                                             input logic [5:0] len_i, input logic [7:0] hop_i);
    lpm_result_t res;
    logic [31:0] a;
    logic [3:0]  c;
    int unsigned rem;
    int unsigned node;
    int unsigned bits;
    int unsigned pos;
    int          p;
    bit          walk_over;
    res       = '0;
    a         = addr_i;
    rem       = (int'(len_i) > tbm_pkg::MAX_LEN) ? tbm_pkg::MAX_LEN : int'(len_i);
    node      = 0;
    walk_over = 1'b0;
    if (op_i == OP_INSERT) begin
      while (rem > 3 && !res.full) begin
        c   = a[31:28];
        a   = a << tbm_pkg::STRIDE;
        rem = rem - tbm_pkg::STRIDE;
        if (!child_bits[node][c]) begin
          if (child_bits[node] == '0) begin
            if (free_block >= tbm_pkg::MAX_BLOCKS) begin
              res.full = 1'b1;
            end else begin
              child_base[node] = tbm_pkg::BLOCK_BITS'(free_block);
              free_block++;
            end
          end
          if (!res.full) child_bits[node][c] = 1'b1;
        end
        if (!res.full) node = int'(child_base[node]) * 16 + int'(c);
      end
      if (!res.full) begin
        bits = (rem != 0) ? (a >> (32 - rem)) : 0;
        pos  = ((1 << rem) - 1) + bits;
        prefix_bits[node][pos]             = 1'b1;
        hop_mem[node * HOPS_PER_NODE + pos] = hop_i;
      end
    end else begin
      while (!walk_over) begin
        if (rem > 3) begin
          c   = a[31:28];
          a   = a << tbm_pkg::STRIDE;
          rem = rem - tbm_pkg::STRIDE;
          p   = match_in_node(node, 32'(c >> 1), 3);
          if (p >= 0) begin
            res.hit = 1'b1;
            res.hop = hop_mem[node * HOPS_PER_NODE + p];
          end
          if (!child_bits[node][c]) walk_over = 1'b1;
          else node = int'(child_base[node]) * 16 + int'(c);
        end else begin
          bits = (rem != 0) ? (a >> (32 - rem)) : 0;
          p    = match_in_node(node, bits, rem);
          if (p >= 0) begin
            res.hit = 1'b1;
            res.hop = hop_mem[node * HOPS_PER_NODE + p];
          end
          walk_over = 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic issue_route_op(input logic op_i, input logic [31:0] addr_i,
                                input logic [5:0] len_i, input logic [7:0] hop_i,
                                input logic typed_i, input lpm_result_t typed_res);
    lpm_result_t pred;
    start         <= 1'b1;
    op            <= op_i;
    address       <= addr_i;
    prefix_length <= len_i;
    next_hop      <= hop_i;
    do @(posedge clk); while (busy);
    pred = route_step(op_i, addr_i, len_i, hop_i);
    pending_results.push_back(typed_i ? typed_res : pred);
    if (op_i == OP_INSERT && !pred.full) route_addrs.push_back(addr_i);
  endtask

  task automatic idle_between();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap        = $urandom_range(0, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [31:0] near_route();
    logic [31:0] base;
    logic [31:0] mask;
    int          k;
    base = route_addrs[$urandom_range(0, route_addrs.size() - 1)];
    k    = $urandom_range(0, 32);
    mask = (k == 32) ? 32'hFFFF_FFFF : ((32'd1 << k) - 32'd1);
    return base ^ ($urandom & mask);
  endfunction

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'({hit, result_hop, table_full}),
                        32'd0);
      end else begin
        oldest = pending_results.pop_front();
        if (hit !== oldest.hit) report_mismatch("hit", 32'(hit), 32'(oldest.hit));
        if (result_hop !== oldest.hop) begin
          report_mismatch("result_hop", 32'(result_hop), 32'(oldest.hop));
        end
        if (table_full !== oldest.full) begin
          report_mismatch("table_full", 32'(table_full), 32'(oldest.full));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** tree_bitmap_ipv4_lpm_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic        r_op;
    logic [31:0] r_addr;
    logic [5:0]  r_len;
    int          sel;
    clk           = 1'b0;
    rst           = 1'b1;
    start         = 1'b0;
    op            = OP_LOOKUP;
    address       = '0;
    prefix_length = '0;
    next_hop      = '0;
    error_count   = 0;
    idle_cycles   = 0;
    burst_left    = 1;
    free_block    = 1;
    foreach (child_bits[i]) begin
      child_bits[i]  = '0;
      prefix_bits[i] = '0;
      child_base[i]  = '0;
    end
    foreach (hop_mem[i]) hop_mem[i] = '0;

    directed_cases = '{
      '{OP_LOOKUP, 32'h0000_0000, 6'd32, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0}},
      '{OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0}},
      '{OP_INSERT, 32'h0000_0000, 6'd0,  8'hAA, 1'b1, '{1'b0, 8'h00, 1'b0}},
      '{OP_LOOKUP, 32'h1234_5678, 6'd32, 8'h00, 1'b1, '{1'b1, 8'hAA, 1'b0}},
      '{OP_INSERT, 32'hFFFF_FFFF, 6'd63, 8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0}},
      '{OP_LOOKUP, 32'hFFFF_FFFF, 6'd32, 8'h00, 1'b1, '{1'b1, 8'hFF, 1'b0}},
      '{OP_LOOKUP, 32'hFFFF_FFFE, 6'd32, 8'h00, 1'b1, '{1'b1, 8'hAA, 1'b0}},
      '{OP_INSERT, 32'h12FF_FFFF, 6'd8,  8'h12, 1'b1, '{1'b0, 8'h00, 1'b0}},
      '{OP_LOOKUP, 32'h1200_0000, 6'd32, 8'h00, 1'b1, '{1'b1, 8'h12, 1'b0}},
      '{OP_LOOKUP, 32'h1200_0000, 6'd0,  8'h00, 1'b1, '{1'b1, 8'hAA, 1'b0}},
      '{OP_INSERT, 32'h8000_0000, 6'd1,  8'h01, 1'b0, '0},
      '{OP_INSERT, 32'hC000_0000, 6'd2,  8'h02, 1'b0, '0},
      '{OP_INSERT, 32'hE000_0000, 6'd3,  8'h03, 1'b0, '0},
      '{OP_LOOKUP, 32'hF000_0000, 6'd32, 8'h00, 1'b0, '0},
      '{OP_LOOKUP, 32'hD000_0000, 6'd32, 8'h00, 1'b0, '0},
      '{OP_LOOKUP, 32'hA000_0000, 6'd3,  8'h00, 1'b0, '0},
      '{OP_LOOKUP, 32'hE000_0000, 6'd2,  8'h00, 1'b0, '0},
      '{OP_INSERT, 32'h1230_0000, 6'd12, 8'h00, 1'b0, '0},
      '{OP_LOOKUP, 32'h1234_0000, 6'd12, 8'h00, 1'b0, '0},
      '{OP_LOOKUP, 32'h1230_0000, 6'd13, 8'h00, 1'b0, '0},
      '{OP_INSERT, 32'h0000_0000, 6'd0,  8'h55, 1'b1, '{1'b0, 8'h00, 1'b0}},
      '{OP_LOOKUP, 32'h0000_0000, 6'd32, 8'h00, 1'b0, '0},
      '{OP_INSERT, 32'h7FFF_FFFF, 6'd31, 8'h80, 1'b0, '0},
      '{OP_LOOKUP, 32'h7FFF_FFFE, 6'd63, 8'h00, 1'b0, '0},
      '{OP_LOOKUP, 32'h7FFF_FFFF, 6'd32, 8'h00, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_cases[i]) begin
      issue_route_op(directed_cases[i].op, directed_cases[i].addr, directed_cases[i].len,
                     directed_cases[i].hop, directed_cases[i].typed, directed_cases[i].want);
      idle_between();
    end
    drain_results();

    // mostly routes near stored prefixes; long inserts eventually exhaust the block pool
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        r_op   = OP_INSERT;
        r_addr = (route_addrs.size() != 0 && $urandom_range(0, 1)) ? near_route() : $urandom;
        sel    = $urandom_range(0, 99);
        if (sel < 50) r_len = 6'($urandom_range(0, 16));
        else if (sel < 85) r_len = 6'($urandom_range(17, 32));
        else r_len = 6'($urandom_range(33, 63));
      end else begin
        r_op   = OP_LOOKUP;
        r_addr = (route_addrs.size() != 0 && $urandom_range(0, 3) != 0) ? near_route()
                                                                         : $urandom;
        sel    = $urandom_range(0, 99);
        if (sel < 75) r_len = 6'd32;
        else if (sel < 90) r_len = 6'($urandom_range(0, 31));
        else r_len = 6'($urandom_range(33, 63));
      end
      issue_route_op(r_op, r_addr, r_len, 8'($urandom_range(0, 255)), 1'b0, '0);
      if ($urandom_range(0, 59) == 0) drain_results();
      else idle_between();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** tree_bitmap_ipv4_lpm_unit: PASSED **");
    end else begin
      $display("** tree_bitmap_ipv4_lpm_unit: FAILED **");
    end
    $finish;
  end

endmodule
